// File: rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle check, off while in reset
`define EIK_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("eikonal node update check failed");

// next-cycle check, off while in reset
`define EIK_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("eikonal node update check failed");

`endif

// File: rtl/core/eik_pkg.sv
package eik_pkg;

    localparam int IDX_W     = 10;
    localparam int TIME_W    = 32;
    localparam int SLOW_W    = 24;
    localparam int CFG_W     = SLOW_W;
    localparam int CFG_IDX_W = 1;
    localparam int SUM_W     = TIME_W + 1;
    localparam int SQ_W      = 2 * SLOW_W;
    localparam int RAD_W     = 2 * SLOW_W + 2;
    localparam int ROOT_W    = RAD_W / 2;
    localparam int REM_W     = ROOT_W + 1;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = 2;
    localparam int Q_CNT_W   = 3;

    localparam logic [IDX_W-1:0]  RESET_LAST_INDEX = 10'd200;
    localparam logic [SLOW_W-1:0] RESET_SLOWNESS   = 24'd16384;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LAST_INDEX,
        CFG_SLOWNESS
    } cfg_reg_t;

    typedef struct packed {
        logic              two;
        logic [SUM_W-1:0]  sum_ab;
        logic [TIME_W-1:0] min_ab;
        logic [SLOW_W-1:0] dlt;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// File: rtl/core/eik_front.sv
module eik_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [eik_pkg::IDX_W-1:0]  last_index,
    input  logic [eik_pkg::SLOW_W-1:0] slowness,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [eik_pkg::IDX_W-1:0]  s_row,
    input  logic [eik_pkg::IDX_W-1:0]  s_col,
    input  logic [eik_pkg::TIME_W-1:0] s_t_above,
    input  logic [eik_pkg::TIME_W-1:0] s_t_below,
    input  logic [eik_pkg::TIME_W-1:0] s_t_left,
    input  logic [eik_pkg::TIME_W-1:0] s_t_right,
    input  eik_pkg::q_stat_t           q_stat,
    output logic                       q_push,
    output eik_pkg::item_t             q_item
);
    import eik_pkg::*;

    function automatic logic [TIME_W-1:0] axis_min(
        input logic [IDX_W-1:0]  idx,
        input logic [IDX_W-1:0]  last,
        input logic [TIME_W-1:0] lo_side,
        input logic [TIME_W-1:0] hi_side
    );
        logic [TIME_W-1:0] res;
        if (idx == '0) begin
            res = hi_side;
        end else if (idx >= last) begin
            res = lo_side;
        end else begin
            res = (lo_side < hi_side) ? lo_side : hi_side;
        end
        return res;
    endfunction

    logic              valid_reg, valid_next;
    logic [TIME_W-1:0] a_reg, b_reg;
    logic              accept;
    logic [TIME_W:0]   a_minus_b;
    logic              a_lt_b;
    logic [TIME_W-1:0] gap_val;

    assign s_ready = !valid_reg || !q_stat.full;
    assign accept  = s_valid && s_ready;
    assign q_push  = valid_reg && !q_stat.full;

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (q_push) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            a_reg <= axis_min(s_row, last_index, s_t_above, s_t_below);
            b_reg <= axis_min(s_col, last_index, s_t_left, s_t_right);
        end
    end

    // classify: two-sided when slowness exceeds the gap
    always_comb begin
        a_minus_b     = {1'b0, a_reg} - {1'b0, b_reg};
        a_lt_b        = a_minus_b[TIME_W];
        gap_val       = a_lt_b ? (b_reg - a_reg) : a_minus_b[TIME_W-1:0];
        q_item.two    = {{(TIME_W-SLOW_W){1'b0}}, slowness} > gap_val;
        q_item.sum_ab = {1'b0, a_reg} + {1'b0, b_reg};
        q_item.min_ab = a_lt_b ? a_reg : b_reg;
        q_item.dlt    = gap_val[SLOW_W-1:0];
    end

endmodule

// File: rtl/core/eik_queue.sv
module eik_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  eik_pkg::item_t   push_item,
    input  logic             pop,
    output eik_pkg::item_t   pop_item,
    output eik_pkg::q_stat_t stat
);
    import eik_pkg::*;

    item_t              mem [0:Q_DEPTH-1];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;

    assign stat.full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign pop_item   = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: rtl/core/eik_back.sv
module eik_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [eik_pkg::SLOW_W-1:0] slowness,
    input  eik_pkg::q_stat_t           q_stat,
    input  eik_pkg::item_t             q_item,
    output logic                       q_pop,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [eik_pkg::TIME_W-1:0] m_new_time,
    output logic                       m_two_sided
);
    import eik_pkg::*;

    logic adv;

    logic              e_valid_reg;
    item_t             e_item_reg;
    logic              p_valid_reg;
    item_t             p_item_reg;
    logic [SQ_W-1:0]   p_ff_reg, p_dd_reg;
    logic [SQ_W-1:0]   ff_prod, dd_prod;

    logic              sq_valid_reg [0:ROOT_W];
    item_t             sq_item_reg  [0:ROOT_W];
    logic [RAD_W-1:0]  sq_rad_reg   [0:ROOT_W];
    logic [REM_W-1:0]  sq_rem_reg   [0:ROOT_W];
    logic [ROOT_W-1:0] sq_root_reg  [0:ROOT_W];

    logic              out_valid_reg;
    logic [TIME_W-1:0] out_time_reg;
    logic              out_two_reg;

    item_t             fin_item;
    logic [SUM_W:0]    two_sum;
    logic [SUM_W-1:0]  one_sum;
    logic [SUM_W-1:0]  res;
    logic [TIME_W-1:0] res_sat;

    // whole back end moves together, frozen while the output is held
    assign adv   = !out_valid_reg || m_ready;
    assign q_pop = adv && !q_stat.empty;

    assign ff_prod = SQ_W'(slowness) * SQ_W'(slowness);
    assign dd_prod = SQ_W'(e_item_reg.dlt) * SQ_W'(e_item_reg.dlt);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg     <= 1'b0;
            p_valid_reg     <= 1'b0;
            sq_valid_reg[0] <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else if (adv) begin
            e_valid_reg     <= !q_stat.empty;
            p_valid_reg     <= e_valid_reg;
            sq_valid_reg[0] <= p_valid_reg;
            out_valid_reg   <= sq_valid_reg[ROOT_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            e_item_reg     <= q_item;
            p_item_reg     <= e_item_reg;
            p_ff_reg       <= ff_prod;
            p_dd_reg       <= dd_prod;
            sq_item_reg[0] <= p_item_reg;
            sq_rad_reg[0]  <= {1'b0, p_ff_reg, 1'b0} - {2'b00, p_dd_reg};
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            out_time_reg   <= res_sat;
            out_two_reg    <= fin_item.two;
        end
    end

    // integer square root, one result bit per stage
    for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
        logic [REM_W+1:0] rem_sh;
        logic [REM_W+1:0] trial;
        logic             take;

        always_comb begin
            rem_sh = {sq_rem_reg[k], sq_rad_reg[k][RAD_W-1 -: 2]};
            trial  = {1'b0, sq_root_reg[k], 2'b01};
            take   = rem_sh >= trial;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_valid_reg[k+1] <= 1'b0;
            end else if (adv) begin
                sq_valid_reg[k+1] <= sq_valid_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                sq_item_reg[k+1] <= sq_item_reg[k];
                sq_rad_reg[k+1]  <= {sq_rad_reg[k][RAD_W-3:0], 2'b00};
                if (take) begin
                    sq_rem_reg[k+1]  <= REM_W'(rem_sh - trial);
                    sq_root_reg[k+1] <= {sq_root_reg[k][ROOT_W-2:0], 1'b1};
                end else begin
                    sq_rem_reg[k+1]  <= rem_sh[REM_W-1:0];
                    sq_root_reg[k+1] <= {sq_root_reg[k][ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        fin_item = sq_item_reg[ROOT_W];
        two_sum  = {1'b0, fin_item.sum_ab}
                 + {{(SUM_W+1-ROOT_W){1'b0}}, sq_root_reg[ROOT_W]};
        one_sum  = {1'b0, fin_item.min_ab} + {{(SUM_W-SLOW_W){1'b0}}, slowness};
        res      = fin_item.two ? two_sum[SUM_W:1] : one_sum;
        res_sat  = res[TIME_W] ? '1 : res[TIME_W-1:0];
    end

    assign m_valid     = out_valid_reg;
    assign m_new_time  = out_time_reg;
    assign m_two_sided = out_two_reg;

endmodule

// File: rtl/core/eikonal_node_update_unit.sv
// channel   | direction | transaction contents
// ----------+-----------+--------------------------------------------------
// s_        | in        | row, col, t_above, t_below, t_left, t_right
// m_        | out       | new_time, two_sided
// cfg_      | in        | write of last_index (0) or slowness (1), no wait
//
// one node per cycle sustained while m_ready stays high; most of the path is the 25-stage square root pipeline
// from input to output register a node passes the front register, the queue, the e and p stages and the root stages
// reset clears all valid flags and the queue, and loads last_index 200, slowness 1.0
// m_ready low freezes the back end; the 4-entry queue keeps the front accepting
// s_ready falls only when the front register is held and the queue is full

`include "assert_macros.svh"

module eikonal_node_update_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_write,
    input  logic [eik_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [eik_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [eik_pkg::IDX_W-1:0]     s_row,
    input  logic [eik_pkg::IDX_W-1:0]     s_col,
    input  logic [eik_pkg::TIME_W-1:0]    s_t_above,
    input  logic [eik_pkg::TIME_W-1:0]    s_t_below,
    input  logic [eik_pkg::TIME_W-1:0]    s_t_left,
    input  logic [eik_pkg::TIME_W-1:0]    s_t_right,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [eik_pkg::TIME_W-1:0]    m_new_time,
    output logic                          m_two_sided
);
    import eik_pkg::*;

    logic [IDX_W-1:0]  last_index_reg, last_index_next;
    logic [SLOW_W-1:0] slowness_reg, slowness_next;

    logic    q_push, q_pop;
    item_t   push_item, pop_item;
    q_stat_t q_stat;

    logic [TIME_W-1:0] slow_floor;

    always_comb begin
        last_index_next = last_index_reg;
        slowness_next   = slowness_reg;
        if (cfg_write) begin
            case (cfg_reg_t'(cfg_index))
                CFG_LAST_INDEX: begin
                    last_index_next = cfg_wdata[IDX_W-1:0];
                end
                CFG_SLOWNESS: begin
                    slowness_next = cfg_wdata[SLOW_W-1:0];
                end
                default: begin
                    last_index_next = last_index_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_index_reg <= RESET_LAST_INDEX;
            slowness_reg   <= RESET_SLOWNESS;
        end else begin
            last_index_reg <= last_index_next;
            slowness_reg   <= slowness_next;
        end
    end

    eik_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .last_index (last_index_reg),
        .slowness   (slowness_reg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_row      (s_row),
        .s_col      (s_col),
        .s_t_above  (s_t_above),
        .s_t_below  (s_t_below),
        .s_t_left   (s_t_left),
        .s_t_right  (s_t_right),
        .q_stat     (q_stat),
        .q_push     (q_push),
        .q_item     (push_item)
    );

    eik_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .stat      (q_stat)
    );

    eik_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .slowness    (slowness_reg),
        .q_stat      (q_stat),
        .q_item      (pop_item),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_new_time  (m_new_time),
        .m_two_sided (m_two_sided)
    );

    assign slow_floor = {{(TIME_W-SLOW_W){1'b0}}, slowness_reg};

    `EIK_ASSERT(a_no_push_when_full, !(q_push && q_stat.full))
    `EIK_ASSERT(a_no_pop_when_stalled, (m_valid && !m_ready) |-> !q_pop)
    `EIK_ASSERT(a_one_sided_floor, (m_valid && !m_two_sided) |-> (m_new_time >= slow_floor))
    `EIK_ASSERT_NEXT(a_empty_holds, q_stat.empty && !q_push, q_stat.empty)

endmodule
